// File: rtl/core/cascade_timer_bank_assert.svh
// Assertion macros for the timer bank RTL.
// Each macro expects clk_i and rst_ni in the scope of use.
`ifndef CASCADE_TIMER_BANK_ASSERT_SVH
`define CASCADE_TIMER_BANK_ASSERT_SVH

// Check cons in the same cycle as ante.
`define CTB_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define CTB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/ctb_pkg.sv
package ctb_pkg;

  // Fixed field widths of the register port
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned SEL_W   = 2;
  localparam int unsigned DATA_W  = 16;
  localparam int unsigned MASK_W  = 4;
  localparam int unsigned PS_W    = 10;
  localparam int unsigned PERIOD_W = PS_W + 1;

  // Defaults for the top-level parameters
  localparam int unsigned NUM_TIMERS_DEF  = 4;
  localparam int unsigned COUNT_WIDTH_DEF = 16;

  // Transaction kinds
  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_READ  = 2'd2
  } func_e;

  // Register select codes
  localparam logic REG_COUNT = 1'b0;
  localparam logic REG_CTRL  = 1'b1;

  // Control register bit positions
  localparam int unsigned CTRL_PS_LSB   = 0;
  localparam int unsigned CTRL_CASC_BIT = 2;
  localparam int unsigned CTRL_IRQ_BIT  = 6;
  localparam int unsigned CTRL_EN_BIT   = 7;

  // Prescale select codes
  localparam logic [1:0] PS_DIV1    = 2'd0;
  localparam logic [1:0] PS_DIV64   = 2'd1;
  localparam logic [1:0] PS_DIV256  = 2'd2;
  localparam logic [1:0] PS_DIV1024 = 2'd3;

  typedef struct packed {
    logic       enable;
    logic       irq_en;
    logic       cascade;
    logic [1:0] prescale;
  } ctrl_t;

  // Command broadcast to every timer cell
  typedef struct packed {
    logic              tick;
    logic              wr_reload;
    logic              wr_ctrl;
    logic [DATA_W-1:0] wdata;
  } cell_cmd_t;

  // One result transaction
  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [MASK_W-1:0] overflow_mask;
    logic [MASK_W-1:0] irq_mask;
  } rsp_t;

  // Prescaler period for a select code
  function automatic logic [PERIOD_W-1:0] ps_period(input logic [1:0] sel);
    logic [PERIOD_W-1:0] p;
    case (sel)
      PS_DIV1:   p = PERIOD_W'(1);
      PS_DIV64:  p = PERIOD_W'(64);
      PS_DIV256: p = PERIOD_W'(256);
      default:   p = PERIOD_W'(1024);
    endcase
    return p;
  endfunction

  // Decode control bits from write data
  function automatic ctrl_t ctrl_from_data(input logic [DATA_W-1:0] d);
    ctrl_t c;
    c.prescale = d[CTRL_PS_LSB +: 2];
    c.cascade  = d[CTRL_CASC_BIT];
    c.irq_en   = d[CTRL_IRQ_BIT];
    c.enable   = d[CTRL_EN_BIT];
    return c;
  endfunction

  // Encode control bits into the read layout
  function automatic logic [DATA_W-1:0] ctrl_to_data(input ctrl_t c);
    logic [DATA_W-1:0] d;
    d = '0;
    d[CTRL_PS_LSB +: 2] = c.prescale;
    d[CTRL_CASC_BIT]    = c.cascade;
    d[CTRL_IRQ_BIT]     = c.irq_en;
    d[CTRL_EN_BIT]      = c.enable;
    return d;
  endfunction

endpackage

// File: rtl/core/ctb_if.sv
// Request channel: one tick, register write or register read per transaction
interface ctb_req_if;
  logic                       valid;
  logic                       ready;
  logic [ctb_pkg::FUNC_W-1:0] func;
  logic [ctb_pkg::SEL_W-1:0]  timer_sel;
  logic                       reg_sel;
  logic [ctb_pkg::DATA_W-1:0] write_data;

  modport source (output valid, func, timer_sel, reg_sel, write_data, input ready);
  modport sink   (input valid, func, timer_sel, reg_sel, write_data, output ready);
endinterface

// Response channel: one result per request
interface ctb_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [ctb_pkg::DATA_W-1:0] read_data;
  logic [ctb_pkg::MASK_W-1:0] overflow_mask;
  logic [ctb_pkg::MASK_W-1:0] irq_mask;

  modport source (output valid, read_data, overflow_mask, irq_mask, input ready);
  modport sink   (input valid, read_data, overflow_mask, irq_mask, output ready);
endinterface

// File: rtl/core/ctb_cell.sv
module ctb_cell #(
  parameter int unsigned COUNT_WIDTH = ctb_pkg::COUNT_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ctb_pkg::cell_cmd_t     cmd_i,
  input  logic                   prev_ovf_i,
  output logic                   ovf_o,
  output logic                   irq_o,
  output logic [COUNT_WIDTH-1:0] count_o,
  output ctb_pkg::ctrl_t         ctrl_o
);
  import ctb_pkg::*;

  logic [COUNT_WIDTH-1:0] reload_q, reload_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  ctrl_t                  ctrl_q, ctrl_d;
  logic [PS_W-1:0]        ps_q, ps_d;

  logic [PS_W-1:0] ps_inc;
  logic            ps_hit;
  logic            step;
  logic            ovf;
  ctrl_t           ctrl_new;

  // Prescaler: fire when the incremented count wraps or reaches the period
  assign ps_inc = ps_q + PS_W'(1);
  assign ps_hit = (ps_inc == '0) || ({1'b0, ps_inc} >= ps_period(ctrl_q.prescale));

  // Count on a prescaler hit, or on the lower neighbor's overflow in cascade mode
  assign step = ctrl_q.enable && (ctrl_q.cascade ? prev_ovf_i : ps_hit);
  assign ovf  = cmd_i.tick && step && (count_q == '1);

  assign ctrl_new = ctrl_from_data(cmd_i.wdata);

  // Next state
  always_comb begin
    reload_d = reload_q;
    count_d  = count_q;
    ctrl_d   = ctrl_q;
    ps_d     = ps_q;
    if (cmd_i.tick) begin
      if (ctrl_q.enable && !ctrl_q.cascade) begin
        ps_d = ps_hit ? '0 : ps_inc;
      end
      if (step) begin
        count_d = (count_q == '1) ? reload_q : count_q + COUNT_WIDTH'(1);
      end
    end
    if (cmd_i.wr_reload) begin
      reload_d = COUNT_WIDTH'(cmd_i.wdata);
    end
    if (cmd_i.wr_ctrl) begin
      ctrl_d = ctrl_new;
      // Rising enable restarts from reload
      if (ctrl_new.enable && !ctrl_q.enable) begin
        count_d = reload_q;
        ps_d    = '0;
      end
    end
  end

  // Hold timer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reload_q <= '0;
      count_q  <= '0;
      ctrl_q   <= '0;
      ps_q     <= '0;
    end else begin
      reload_q <= reload_d;
      count_q  <= count_d;
      ctrl_q   <= ctrl_d;
      ps_q     <= ps_d;
    end
  end

  assign ovf_o   = ovf;
  assign irq_o   = ovf && ctrl_q.irq_en;
  assign count_o = count_q;
  assign ctrl_o  = ctrl_q;

endmodule

// File: rtl/core/ctb_out_buf.sv
module ctb_out_buf (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ctb_pkg::rsp_t   data_i,
  output logic            ready_o,
  output logic            valid_o,
  input  logic            pop_ready_i,
  output ctb_pkg::rsp_t   data_o
);
  import ctb_pkg::*;

  rsp_t main_q, main_d;
  rsp_t skid_q, skid_d;
  logic main_vld_q, main_vld_d;
  logic skid_vld_q, skid_vld_d;
  logic pop;

  assign pop     = main_vld_q && pop_ready_i;
  assign ready_o = !skid_vld_q;

  // Advance the two-entry queue: output register plus skid register
  always_comb begin
    main_d     = main_q;
    skid_d     = skid_q;
    main_vld_d = main_vld_q;
    skid_vld_d = skid_vld_q;
    if (pop) begin
      if (skid_vld_q) begin
        main_d     = skid_q;
        skid_vld_d = 1'b0;
      end else begin
        main_vld_d = push_i;
        main_d     = data_i;
      end
    end else if (push_i) begin
      if (!main_vld_q) begin
        main_d     = data_i;
        main_vld_d = 1'b1;
      end else begin
        skid_d     = data_i;
        skid_vld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      main_vld_q <= main_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign valid_o = main_vld_q;
  assign data_o  = main_q;

endmodule

// File: rtl/core/cascade_timer_bank.sv
// Bank of NUM_TIMERS up-counting timers of COUNT_WIDTH bits, driven through a
// request/response stream. Every request is a tick, a register write or a
// register read and yields exactly one response; one request is taken every
// cycle while the skid register is empty. Responses are registered in a
// two-entry output queue, so a stalled response does not stop the next
// request. Each timer is a cell in a row; on a tick the overflow of one cell
// feeds the next within the same cycle, so the cascade ripple through
// NUM_TIMERS cells sets the longest path. Control layout: bits 1:0 prescale
// (1/64/256/1024), bit 2 cascade, bit 6 IRQ enable, bit 7 enable. Writing the
// count register sets the reload value only; reads of absent timers return
// zero; the masks cover timers 0 to 3.
module cascade_timer_bank #(
  parameter int unsigned NUM_TIMERS  = ctb_pkg::NUM_TIMERS_DEF,
  parameter int unsigned COUNT_WIDTH = ctb_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ctb_req_if.sink     req_i,
  ctb_rsp_if.source   rsp_o
);
  import ctb_pkg::*;

  `include "cascade_timer_bank_assert.svh"

  logic                   req_acc;
  logic                   buf_ready;
  logic [NUM_TIMERS-1:0]  sel_hit;
  logic [NUM_TIMERS-1:0]  ovf_vec;
  logic [NUM_TIMERS-1:0]  irq_vec;
  logic [NUM_TIMERS:0]    chain;
  logic [NUM_TIMERS+MASK_W-1:0] ovf_ext;
  logic [NUM_TIMERS+MASK_W-1:0] irq_ext;
  logic [DATA_W-1:0]      rd_val [NUM_TIMERS];
  logic [DATA_W-1:0]      rd_mux;
  ctrl_t                  ctrl_vec [NUM_TIMERS];
  cell_cmd_t              cmd [NUM_TIMERS];
  rsp_t                   rsp_new;
  rsp_t                   rsp_out;
  logic                   is_tick;
  logic                   is_write;
  logic                   is_read;

  assign req_i.ready = buf_ready;
  assign req_acc     = req_i.valid && buf_ready;

  assign is_tick  = req_acc && (req_i.func == FUNC_TICK);
  assign is_write = req_acc && (req_i.func == FUNC_WRITE);
  assign is_read  = (req_i.func == FUNC_READ);

  // No timer below timer 0 to cascade from
  assign chain[0] = 1'b0;

  // Row of timer cells
  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    logic [COUNT_WIDTH-1:0] count;

    assign sel_hit[i] = (32'(req_i.timer_sel) == i);

    assign cmd[i].tick      = is_tick;
    assign cmd[i].wr_reload = is_write && sel_hit[i] && (req_i.reg_sel == REG_COUNT);
    assign cmd[i].wr_ctrl   = is_write && sel_hit[i] && (req_i.reg_sel == REG_CTRL);
    assign cmd[i].wdata     = req_i.write_data;

    ctb_cell #(
      .COUNT_WIDTH(COUNT_WIDTH)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd[i]),
      .prev_ovf_i (chain[i]),
      .ovf_o      (ovf_vec[i]),
      .irq_o      (irq_vec[i]),
      .count_o    (count),
      .ctrl_o     (ctrl_vec[i])
    );

    assign chain[i+1] = ovf_vec[i];

    // Register read value of this cell, zero when not addressed
    assign rd_val[i] = !sel_hit[i]              ? '0 :
                       (req_i.reg_sel == REG_CTRL) ? ctrl_to_data(ctrl_vec[i]) :
                       DATA_W'(count);
  end

  // Combine the per-cell read values
  always_comb begin
    rd_mux = '0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      rd_mux = rd_mux | rd_val[i];
    end
  end

  // Keep only timers 0 to 3 in the masks
  assign ovf_ext = {{MASK_W{1'b0}}, ovf_vec};
  assign irq_ext = {{MASK_W{1'b0}}, irq_vec};

  // Form the response transaction
  always_comb begin
    rsp_new.read_data     = is_read ? rd_mux : '0;
    rsp_new.overflow_mask = is_tick ? ovf_ext[MASK_W-1:0] : '0;
    rsp_new.irq_mask      = is_tick ? irq_ext[MASK_W-1:0] : '0;
  end

  ctb_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (req_acc),
    .data_i      (rsp_new),
    .ready_o     (buf_ready),
    .valid_o     (rsp_o.valid),
    .pop_ready_i (rsp_o.ready),
    .data_o      (rsp_out)
  );

  assign rsp_o.read_data     = rsp_out.read_data;
  assign rsp_o.overflow_mask = rsp_out.overflow_mask;
  assign rsp_o.irq_mask      = rsp_out.irq_mask;

  // Interrupts only accompany overflows
  `CTB_ASSERT_SAME(a_irq_subset, rsp_o.valid, (rsp_o.irq_mask & ~rsp_o.overflow_mask) == '0, "irq without overflow")
  // An accepted request into an empty queue shows up next cycle
  `CTB_ASSERT_NEXT(a_rsp_latency, req_acc && !rsp_o.valid, rsp_o.valid, "response missing")
  // Backpressure only while a response is pending
  `CTB_ASSERT_SAME(a_stall_pending, !req_i.ready, rsp_o.valid, "stall with empty output")
  // Timer 0 in cascade mode never overflows
  `CTB_ASSERT_SAME(a_casc0_silent, ctrl_vec[0].cascade, !ovf_vec[0], "cascaded timer 0 counted")

endmodule
